// ----- hdl/tpc_pkg.sv -----
// Shared constants and types for the trie prefix counter.
// No dependencies; imported by every module of the block.
package tpc_pkg;

	localparam int MAX_NODES_DEF  = 4096;
	localparam int ALPHABET_DEF   = 26;
	localparam int COUNT_BITS_DEF = 20;

	localparam int LETTER_W    = 5;
	localparam int OUT_COUNT_W = 20;
	localparam logic [31:0] OUT_COUNT_MAX = 32'h000F_FFFF;

	localparam int FIFO_DEPTH = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic                query;
		logic                sym_ok;
		logic [LETTER_W-1:0] letter;
		logic                last;
	} cmd_t;

endpackage

// ----- hdl/trie_prefix_counter.sv -----
// Trie prefix counter, top level. A letter that walks the trie is handled in the back
// part by a child-table read, then write-back and cursor update; a letter that is
// ignored or follows a stopped walk skips the read. After reset the child table is
// cleared one row per cycle, all MAX_NODES rows, during which in_ready stays low.
// Depends on tpc_pkg and the tpc_* modules.
module trie_prefix_counter
	import tpc_pkg::*;
#(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int ALPHABET   = ALPHABET_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   func,
	input  logic [LETTER_W-1:0]    letter,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_COUNT_W-1:0] count,
	output logic                   pool_full
);

	logic busy;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	tpc_front #(
		.ALPHABET(ALPHABET)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.letter    (letter),
		.last      (last),
		.busy      (busy),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	tpc_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop)
	);

	tpc_back #(
		.MAX_NODES (MAX_NODES),
		.ALPHABET  (ALPHABET),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.count     (count),
		.pool_full (pool_full)
	);

endmodule

// ----- hdl/tpc_front.sv -----
// Input stage of the trie prefix counter: accepts items and classifies them.
// Depends on tpc_pkg; feeds tpc_cmd_fifo.
module tpc_front
	import tpc_pkg::*;
#(
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [LETTER_W-1:0] letter,
	input  logic                last,
	input  logic                busy,
	output logic                push_valid,
	input  logic                push_ready,
	output cmd_t                push_cmd
);

	logic vld_s1;
	cmd_t cmd_s1;

	assign in_ready   = !busy && (!vld_s1 || push_ready);
	assign push_valid = vld_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.query  <= (func == FUNC_QUERY);
			cmd_s1.sym_ok <= (32'(letter) < 32'(ALPHABET));
			cmd_s1.letter <= letter;
			cmd_s1.last   <= last;
		end
	end

endmodule

// ----- hdl/tpc_cmd_fifo.sv -----
// Short command queue between the front and back parts.
// Depends on tpc_pkg for the command type and its depth.
module tpc_cmd_fifo
	import tpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(FIFO_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hdl/tpc_back.sv -----
// Back part of the trie prefix counter: walks the child table and drives results.
// Depends on tpc_pkg; takes commands from tpc_cmd_fifo.
module tpc_back
	import tpc_pkg::*;
#(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int ALPHABET   = ALPHABET_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  cmd_t                   head_cmd,
	output logic                   pop,
	output logic                   busy,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_COUNT_W-1:0] count,
	output logic                   pool_full
);

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int LANE_W  = $clog2(ALPHABET);
	localparam int ENTRY_W = NODE_W + COUNT_BITS;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXE  = 2'd2;

	// Each entry holds the child id and the prefix count of that child.
	logic [ALPHABET-1:0][ENTRY_W-1:0] mem_q [MAX_NODES];
	logic [ENTRY_W-1:0]               rd_q;

	logic [1:0]            state_q;
	logic [NODE_W-1:0]     clr_q;
	cmd_t                  cmd_q;
	logic [NODE_W-1:0]     cursor_q;
	logic [COUNT_BITS-1:0] cur_cnt_q;
	logic                  missed_q;
	logic                  ovf_q;
	logic [NODE_W:0]       next_free_q;
	logic                  out_valid_q;
	logic [OUT_COUNT_W-1:0] count_q;
	logic                  pool_full_q;

	logic                  out_free;
	logic                  walk;
	logic                  rd_en;
	logic                  wr_en;
	logic [ENTRY_W-1:0]    wr_data;
	logic [LANE_W-1:0]     head_lane;
	logic [LANE_W-1:0]     cmd_lane;
	logic [NODE_W-1:0]     rd_id;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] inc_cnt;
	logic                  finish;
	logic                  fin_query;
	logic [NODE_W-1:0]     n_cursor;
	logic [COUNT_BITS-1:0] n_cnt;
	logic                  n_missed;
	logic                  n_ovf;
	logic [NODE_W:0]       n_free;
	logic [1:0]            n_state;
	logic [31:0]           cnt_wide;
	logic [OUT_COUNT_W-1:0] res_count;

	assign out_free  = !out_valid_q || out_ready;
	assign busy      = (state_q == ST_CLR);
	assign head_lane = LANE_W'(head_cmd.letter);
	assign cmd_lane  = LANE_W'(cmd_q.letter);
	assign walk      = !missed_q && !ovf_q && head_cmd.sym_ok;
	assign pop       = (state_q == ST_IDLE) && head_valid && (!head_cmd.last || out_free);
	assign rd_en     = pop && walk;
	assign rd_id     = rd_q[ENTRY_W-1 -: NODE_W];
	assign rd_cnt    = rd_q[COUNT_BITS-1:0];
	assign inc_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

	always_comb begin
		n_cursor  = cursor_q;
		n_cnt     = cur_cnt_q;
		n_missed  = missed_q;
		n_ovf     = ovf_q;
		n_free    = next_free_q;
		n_state   = state_q;
		wr_en     = 1'b0;
		wr_data   = '0;
		finish    = 1'b0;
		fin_query = 1'b0;
		case (state_q)
			ST_CLR: begin
				if (clr_q == NODE_W'(MAX_NODES - 1)) begin
					n_state = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					if (walk) begin
						n_state = ST_EXE;
					end else begin
						if (!missed_q && !ovf_q && head_cmd.query) begin
							n_missed = 1'b1;
						end
						finish    = head_cmd.last;
						fin_query = head_cmd.query;
					end
				end
			end
			ST_EXE: begin
				n_state = ST_IDLE;
				if (cmd_q.query) begin
					if (rd_id == '0) begin
						n_missed = 1'b1;
					end else begin
						n_cursor = rd_id;
						n_cnt    = rd_cnt;
					end
				end else if (rd_id == '0) begin
					if (next_free_q == (NODE_W + 1)'(MAX_NODES)) begin
						n_ovf = 1'b1;
					end else begin
						wr_en    = 1'b1;
						wr_data  = {next_free_q[NODE_W-1:0], COUNT_BITS'(1)};
						n_cursor = next_free_q[NODE_W-1:0];
						n_cnt    = COUNT_BITS'(1);
						n_free   = next_free_q + 1'b1;
					end
				end else begin
					wr_en    = 1'b1;
					wr_data  = {rd_id, inc_cnt};
					n_cursor = rd_id;
					n_cnt    = inc_cnt;
				end
				finish    = cmd_q.last;
				fin_query = cmd_q.query;
			end
			default: begin
				n_state = ST_IDLE;
			end
		endcase
	end

	assign cnt_wide  = 32'(n_cnt);
	assign res_count = (cnt_wide > OUT_COUNT_MAX) ? OUT_COUNT_W'(OUT_COUNT_MAX)
		: cnt_wide[OUT_COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cursor_q    <= '0;
			cur_cnt_q   <= '0;
			missed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			next_free_q <= (NODE_W + 1)'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= n_state;
			next_free_q <= n_free;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (finish) begin
				cursor_q  <= '0;
				cur_cnt_q <= '0;
				missed_q  <= 1'b0;
				ovf_q     <= 1'b0;
			end else begin
				cursor_q  <= n_cursor;
				cur_cnt_q <= n_cnt;
				missed_q  <= n_missed;
				ovf_q     <= n_ovf;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && walk) begin
			cmd_q <= head_cmd;
		end
		if (finish) begin
			count_q     <= (fin_query && !n_missed && !n_ovf) ? res_count : '0;
			pool_full_q <= !fin_query && n_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			mem_q[clr_q] <= '0;
		end else if (wr_en) begin
			mem_q[cursor_q][cmd_lane] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[cursor_q][head_lane];
		end
	end

	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign pool_full = pool_full_q;

endmodule
